@@ rtl/wavhp_pkg.sv @@
// ----------------------------------------------------------------------------
// wavhp_pkg - shared types and constants of the WAV header chunk parser
// Request types, result record and header layout constants.
// ----------------------------------------------------------------------------
package wavhp_pkg;

    // Minimum buffer length for a usable header
    localparam logic [31:0] MIN_HEADER_BYTES = 32'd44;
    localparam logic [31:0] FALLBACK_OFFSET  = 32'd44;
    localparam logic [33:0] FIRST_CHUNK      = 34'd12;
    localparam logic [33:0] CHUNK_HDR        = 34'd8;
    localparam logic [31:0] POS_MAX          = 32'hFFFF_FFFF;

    // Header byte positions
    localparam logic [31:0] POS_CHANNELS  = 32'd22;
    localparam logic [31:0] POS_RATE      = 32'd24;
    localparam logic [31:0] POS_BITS      = 32'd34;
    localparam logic [31:0] POS_WAVE      = 32'd8;
    localparam logic [31:0] TAG_LEN       = 32'd4;

    // Tags, first character in the top byte
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [2:0]  HDR_LAST = 3'd7;

    // One input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    // One result
    typedef struct packed {
        logic              header_valid;
        logic [7:0]        channel_count;
        logic signed [31:0] rate_hz;
        logic signed [15:0] sample_bits;
        logic [31:0]       payload_offset;
        logic              payload_found;
    } t_result;

    // Expected character of a four-byte tag at index idx
    function automatic logic [7:0] f_tag_byte(logic [31:0] tag, logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = tag[31:24];
            2'd1:    v = tag[23:16];
            2'd2:    v = tag[15:8];
            default: v = tag[7:0];
        endcase
        return v;
    endfunction

endpackage

@@ rtl/wav_header_chunk_parser_core.sv @@
// ----------------------------------------------------------------------------
// wav_header_chunk_parser_core - WAV/RIFF header parser, one byte per cycle
//
// Slave side: one buffer byte per request on s_tdata, s_tlast on the final
// byte. Master side: one result per buffer, sent after its last byte.
// Result: header_valid and payload_found in tuser; channel count, sample
// rate, sample width and payload offset in tdata (zero when invalid).
// Throughput: one byte per cycle, except while a last byte waits for the
// output register. The last byte is registered at the input, parsed
// combinationally from there, and its result loaded into the output
// register that drives m_tvalid. The path is set by the chunk walk: a
// position compare and a 35-bit saturating add for the next chunk start.
// While a result waits, bytes of the next buffer keep flowing; only a last
// byte waits in the input register until the output register is free.
// Reset (synchronous, active low) empties both registers and restores the
// parse state; the state is also cleared after every buffer end.
// ----------------------------------------------------------------------------
module wav_header_chunk_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [7:0] channel_count, [39:8] rate_hz,
                                   // [55:40] sample_bits, [87:56] payload_offset
    output logic [1:0]  m_tuser    // [0] header_valid, [1] payload_found
);

    wavhp_pkg::t_in_item in_item;
    wavhp_pkg::t_in_item q_item;
    wavhp_pkg::t_result  parse_res;
    wavhp_pkg::t_result  out_res;
    logic                q_valid;
    logic                out_free;
    logic                take;

    assign in_item.data_byte     = s_tdata;
    assign in_item.end_of_buffer = s_tlast;

    // a last byte proceeds only when the result register can take it
    assign take = q_valid && (!q_item.end_of_buffer || out_free);

    wavhp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_item  (in_item),
        .o_ready (s_tready),
        .i_take  (take),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    wavhp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (take),
        .i_item   (q_item),
        .o_result (parse_res)
    );

    wavhp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && q_item.end_of_buffer),
        .i_result (parse_res),
        .o_free   (out_free),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_result (out_res)
    );

    // output packing
    assign m_tdata = {out_res.payload_offset, out_res.sample_bits,
                      out_res.rate_hz, out_res.channel_count};
    assign m_tuser = {out_res.payload_found, out_res.header_valid};

endmodule

@@ rtl/wavhp_in_stage.sv @@
// ----------------------------------------------------------------------------
// wavhp_in_stage - input register of the parser
// Holds one byte request; refills in the same cycle it is consumed.
// ----------------------------------------------------------------------------
module wavhp_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  wavhp_pkg::t_in_item i_item,
    output logic               o_ready,
    input  logic               i_take,
    output logic               o_valid,
    output wavhp_pkg::t_in_item o_item
);

    logic                r_valid;
    wavhp_pkg::t_in_item r_item;
    logic                load;

    assign load    = !r_valid || i_take;
    assign o_ready = load;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

endmodule

@@ rtl/wavhp_parse.sv @@
// ----------------------------------------------------------------------------
// wavhp_parse - header state and chunk walk
// Updates the parse state for one byte per cycle while i_fire is high and
// forms the result from the state as it stands after that byte.
// ----------------------------------------------------------------------------
module wavhp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  wavhp_pkg::t_in_item i_item,
    output wavhp_pkg::t_result  o_result
);

    logic [31:0] r_byte_index, n_byte_index;
    logic        r_tags_ok,    n_tags_ok;
    logic [33:0] r_next_chunk, n_next_chunk;
    logic [31:0] r_name_sh,    n_name_sh;
    logic [31:0] r_len_sh,     n_len_sh;
    logic        r_found,      n_found;
    logic [31:0] r_found_off,  n_found_off;
    logic [7:0]  r_channels,   n_channels;
    logic [31:0] r_rate,       n_rate;
    logic [15:0] r_bits,       n_bits;
    logic        r_in_hdr,     n_in_hdr;
    logic [2:0]  r_hdr_cnt,    n_hdr_cnt;

    logic [31:0] p;
    logic [7:0]  b;
    logic        hdr_now;
    logic [2:0]  d;
    logic [34:0] nxt_sum;
    logic        valid;

    assign p = r_byte_index;
    assign b = i_item.data_byte;

    // next state for one byte
    always_comb begin
        n_byte_index = r_byte_index;
        n_tags_ok    = r_tags_ok;
        n_next_chunk = r_next_chunk;
        n_name_sh    = r_name_sh;
        n_len_sh     = r_len_sh;
        n_found      = r_found;
        n_found_off  = r_found_off;
        n_channels   = r_channels;
        n_rate       = r_rate;
        n_bits       = r_bits;
        n_in_hdr     = r_in_hdr;
        n_hdr_cnt    = r_hdr_cnt;

        hdr_now = !r_found && (r_in_hdr || ({2'b00, p} == r_next_chunk));
        d       = r_in_hdr ? r_hdr_cnt : 3'd0;
        nxt_sum = 35'd0;

        if (p != wavhp_pkg::POS_MAX) begin
            // tag checks
            if (p < wavhp_pkg::TAG_LEN &&
                b != wavhp_pkg::f_tag_byte(wavhp_pkg::TAG_RIFF, p[1:0])) begin
                n_tags_ok = 1'b0;
            end
            if (p >= wavhp_pkg::POS_WAVE && p < wavhp_pkg::POS_WAVE + wavhp_pkg::TAG_LEN &&
                b != wavhp_pkg::f_tag_byte(wavhp_pkg::TAG_WAVE, p[1:0])) begin
                n_tags_ok = 1'b0;
            end

            // field capture, little endian
            if (p == wavhp_pkg::POS_CHANNELS) begin
                n_channels = b;
            end
            if (p >= wavhp_pkg::POS_RATE && p < wavhp_pkg::POS_RATE + 32'd4) begin
                case (p[1:0])
                    2'd0:    n_rate[7:0]   = b;
                    2'd1:    n_rate[15:8]  = b;
                    2'd2:    n_rate[23:16] = b;
                    default: n_rate[31:24] = b;
                endcase
            end
            if (p == wavhp_pkg::POS_BITS) begin
                n_bits[7:0] = b;
            end
            if (p == wavhp_pkg::POS_BITS + 32'd1) begin
                n_bits[15:8] = b;
            end

            // chunk header walk
            if (hdr_now) begin
                if (d < 3'd4) begin
                    n_name_sh = {r_name_sh[23:0], b};
                end else begin
                    n_len_sh = {b, r_len_sh[31:8]};
                end
                if (d == wavhp_pkg::HDR_LAST) begin
                    if (n_name_sh == wavhp_pkg::TAG_DATA) begin
                        n_found     = 1'b1;
                        n_found_off = 32'(r_next_chunk + wavhp_pkg::CHUNK_HDR);
                    end else begin
                        nxt_sum = {1'b0, r_next_chunk} + {1'b0, wavhp_pkg::CHUNK_HDR}
                                + {3'b000, n_len_sh};
                        // saturate at the top of the 34-bit range
                        n_next_chunk = nxt_sum[34] ? '1 : nxt_sum[33:0];
                    end
                    n_name_sh = 32'd0;
                    n_len_sh  = 32'd0;
                    n_in_hdr  = 1'b0;
                    n_hdr_cnt = 3'd0;
                end else begin
                    n_in_hdr  = 1'b1;
                    n_hdr_cnt = d + 3'd1;
                end
            end
            n_byte_index = p + 32'd1;
        end
    end

    // result as seen after this byte; zeros when invalid
    always_comb begin
        valid    = n_tags_ok && (p >= wavhp_pkg::MIN_HEADER_BYTES - 32'd1);
        o_result = '0;
        if (valid) begin
            o_result.header_valid   = 1'b1;
            o_result.channel_count  = n_channels;
            o_result.rate_hz        = n_rate;
            o_result.sample_bits    = n_bits;
            o_result.payload_offset = n_found ? n_found_off : wavhp_pkg::FALLBACK_OFFSET;
            o_result.payload_found  = n_found;
        end
    end

    // state registers; a buffer end clears everything for the next buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.end_of_buffer)) begin
            r_byte_index <= 32'd0;
            r_tags_ok    <= 1'b1;
            r_next_chunk <= wavhp_pkg::FIRST_CHUNK;
            r_name_sh    <= 32'd0;
            r_len_sh     <= 32'd0;
            r_found      <= 1'b0;
            r_found_off  <= 32'd0;
            r_channels   <= 8'd0;
            r_rate       <= 32'd0;
            r_bits       <= 16'd0;
            r_in_hdr     <= 1'b0;
            r_hdr_cnt    <= 3'd0;
        end else if (i_fire) begin
            r_byte_index <= n_byte_index;
            r_tags_ok    <= n_tags_ok;
            r_next_chunk <= n_next_chunk;
            r_name_sh    <= n_name_sh;
            r_len_sh     <= n_len_sh;
            r_found      <= n_found;
            r_found_off  <= n_found_off;
            r_channels   <= n_channels;
            r_rate       <= n_rate;
            r_bits       <= n_bits;
            r_in_hdr     <= n_in_hdr;
            r_hdr_cnt    <= n_hdr_cnt;
        end
    end

    // walk stops once a data chunk is found
    a_hdr_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_hdr |-> !r_found)
        else $error("chunk header walk active after data chunk found");

    // inside a header the byte position sits at chunk start plus offset
    a_hdr_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_hdr |-> ({2'b00, r_byte_index} == r_next_chunk + 34'(r_hdr_cnt)))
        else $error("header offset out of step with byte position");

    // header offset only counts inside a header
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_hdr |-> (r_hdr_cnt == 3'd0))
        else $error("header offset non-zero outside a header");

    // buffer end clears the position
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.end_of_buffer) |=> (r_byte_index == 32'd0 && !r_found))
        else $error("state not cleared after buffer end");

endmodule

@@ rtl/wavhp_out_stage.sv @@
// ----------------------------------------------------------------------------
// wavhp_out_stage - result register of the parser
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module wavhp_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  wavhp_pkg::t_result i_result,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output wavhp_pkg::t_result o_result
);

    logic               r_valid;
    wavhp_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ tb/tb_wav_header_chunk_parser_core.sv @@
// ----------------------------------------------------------------------------
// tb_wav_header_chunk_parser_core - self-checking bench for the WAV parser
// Feeds whole buffers, one byte per request, through the slave stream and
// predicts every header result in step with the accepted bytes. Each result
// on the master stream is checked field by field against the oldest
// prediction. Stimulus is mostly well-formed RIFF/WAVE headers with random
// content and chunk layouts, mixed with broken tags, truncated buffers and
// pure noise, under shifting amounts of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_wav_header_chunk_parser_core;

    localparam int          RANDOM_ITEMS   = 1200;
    localparam int          MIN_FRAMES     = 10;
    localparam int          SETTLE_CYCLES  = 20;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam logic [31:0] TAG_FMT        = 32'h666D_7420;
    localparam logic [31:0] TAG_LIST       = 32'h4C49_5354;
    localparam logic [34:0] WALK_MAX       = 35'h3_FFFF_FFFF;

    // One pending byte request; hold makes the source wait for an empty
    // result store before offering it
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       hold;
    } t_byte_req;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;

    t_byte_req           pending_bytes[$];
    logic [7:0]          frame_q[$];
    wavhp_pkg::t_result  hdr_results_q[$];

    // Parser state mirrored by the predictor
    logic [31:0] pos_q;
    logic        tags_good;
    logic [33:0] walk_start;
    logic [31:0] name_sr;
    logic [31:0] size_sr;
    logic        data_seen;
    logic [31:0] data_off;
    logic [7:0]  chan_cap;
    logic [31:0] rate_cap;
    logic [15:0] bits_cap;

    int          bytes_sent   = 0;
    int          total_items  = 1;
    int          n_frames     = 0;
    int          valid_cnt    = 0;
    int          found_cnt    = 0;
    int          results_seen = 0;
    int          fail_cnt     = 0;
    int          idle_cycles  = 0;
    logic [1:0]  phase        = 2'd0;

    wav_header_chunk_parser_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic clear_parse();
        pos_q      = '0;
        tags_good  = 1'b1;
        walk_start = wavhp_pkg::FIRST_CHUNK;
        name_sr    = '0;
        size_sr    = '0;
        data_seen  = 1'b0;
        data_off   = '0;
        chan_cap   = '0;
        rate_cap   = '0;
        bits_cap   = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [31:0]        p;
        logic [31:0]        sh;
        logic [33:0]        hdr_off;
        logic [34:0]        nxt;
        logic [32:0]        len;
        wavhp_pkg::t_result r;
        int                 k;
        p = pos_q;
        // saturated position: the byte takes no part in parsing
        if (p != wavhp_pkg::POS_MAX) begin
            if (p < 4) begin
                k  = p;
                sh = wavhp_pkg::TAG_RIFF >> (8 * (3 - k));
                if (b != sh[7:0]) tags_good = 1'b0;
            end
            if (p >= wavhp_pkg::POS_WAVE && p < wavhp_pkg::POS_WAVE + wavhp_pkg::TAG_LEN) begin
                k  = p - wavhp_pkg::POS_WAVE;
                sh = wavhp_pkg::TAG_WAVE >> (8 * (3 - k));
                if (b != sh[7:0]) tags_good = 1'b0;
            end
            if (p == wavhp_pkg::POS_CHANNELS) chan_cap = b;
            if (p >= wavhp_pkg::POS_RATE && p < wavhp_pkg::POS_RATE + 4)
                rate_cap = rate_cap | ({24'd0, b} << (8 * (p - wavhp_pkg::POS_RATE)));
            if (p >= wavhp_pkg::POS_BITS && p < wavhp_pkg::POS_BITS + 2)
                bits_cap = bits_cap | ({8'd0, b} << (8 * (p - wavhp_pkg::POS_BITS)));

            // chunk walk: name bytes shift in from the bottom, size is LE
            if (!data_seen && {2'b00, p} >= walk_start
                    && ({2'b00, p} - walk_start) < wavhp_pkg::CHUNK_HDR) begin
                hdr_off = {2'b00, p} - walk_start;
                if (hdr_off < 4) name_sr = {name_sr[23:0], b};
                else             size_sr = {b, size_sr[31:8]};
                if (hdr_off == wavhp_pkg::CHUNK_HDR - 1) begin
                    if (name_sr == wavhp_pkg::TAG_DATA) begin
                        data_seen = 1'b1;
                        nxt       = {1'b0, walk_start} + {1'b0, wavhp_pkg::CHUNK_HDR};
                        data_off  = nxt[31:0];
                    end else begin
                        nxt = {1'b0, walk_start} + {1'b0, wavhp_pkg::CHUNK_HDR}
                            + {3'b000, size_sr};
                        walk_start = (nxt > WALK_MAX) ? WALK_MAX[33:0] : nxt[33:0];
                    end
                    name_sr = '0;
                    size_sr = '0;
                end
            end
            pos_q = p + 32'd1;
        end

        // buffer end: one result, then a fresh parse
        if (last) begin
            len = {1'b0, p} + 33'd1;
            r   = '0;
            if (tags_good && len >= {1'b0, wavhp_pkg::MIN_HEADER_BYTES}) begin
                r.header_valid   = 1'b1;
                r.channel_count  = chan_cap;
                r.rate_hz        = rate_cap;
                r.sample_bits    = bits_cap;
                r.payload_offset = data_seen ? data_off : wavhp_pkg::FALLBACK_OFFSET;
                r.payload_found  = data_seen;
                valid_cnt++;
                if (data_seen) found_cnt++;
            end
            hdr_results_q.push_back(r);
            clear_parse();
        end
    endtask

    // ------------------------------------------------------------------
    // Buffer construction
    // ------------------------------------------------------------------
    task automatic push_tag(input logic [31:0] tag);
        logic [31:0] sh;
        for (int k = 3; k >= 0; k--) begin
            sh = tag >> (8 * k);
            frame_q.push_back(sh[7:0]);
        end
    endtask

    task automatic push_le32(input logic [31:0] w);
        logic [31:0] sh;
        for (int k = 0; k < 4; k++) begin
            sh = w >> (8 * k);
            frame_q.push_back(sh[7:0]);
        end
    endtask

    task automatic push_random(input int n);
        logic [31:0] rnd;
        for (int k = 0; k < n; k++) begin
            rnd = $urandom;
            frame_q.push_back(rnd[7:0]);
        end
    endtask

    // Move the frame under construction onto the request queue
    task automatic emit_frame(input logic hold);
        t_byte_req req;
        for (int i = 0; i < frame_q.size(); i++) begin
            req.data_byte = frame_q[i];
            req.last      = (i == frame_q.size() - 1);
            req.hold      = hold && (i == 0);
            pending_bytes.push_back(req);
        end
    endtask

    task automatic build_frame();
        int          mode;
        int          n;
        int          k;
        logic [31:0] sz;
        logic [7:0]  flip;
        frame_q.delete();
        mode = $urandom_range(0, 99);

        // pure noise
        if (mode >= 90) begin
            push_random($urandom_range(1, 60));
            return;
        end

        push_tag(wavhp_pkg::TAG_RIFF);
        push_le32($urandom);
        push_tag(wavhp_pkg::TAG_WAVE);
        if ($urandom_range(0, 9) == 0) begin
            // data chunk straight after the WAVE tag
            push_tag(wavhp_pkg::TAG_DATA);
            push_le32($urandom);
            push_random($urandom_range(20, 40));
        end else begin
            sz = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 22) : 32'd16;
            push_tag(TAG_FMT);
            push_le32(sz);
            push_random(sz);
            // a few small chunks, now and then one whose size runs far off
            n = $urandom_range(0, 2);
            for (k = 0; k < n; k++) begin
                case ($urandom_range(0, 3))
                    0: begin
                        push_tag(TAG_LIST);
                    end
                    1: begin
                        push_tag(wavhp_pkg::TAG_DATA ^ (32'd1 << $urandom_range(0, 31)));
                    end
                    default: begin
                        push_le32($urandom);
                    end
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    push_le32($urandom);
                    push_random($urandom_range(0, 6));
                end else begin
                    sz = $urandom_range(0, 6);
                    push_le32(sz);
                    push_random(sz);
                end
            end
            if ($urandom_range(0, 4) != 0) begin
                push_tag(wavhp_pkg::TAG_DATA);
                push_le32($urandom);
                push_random($urandom_range(0, 6));
                // a second data chunk must be ignored
                if ($urandom_range(0, 3) == 0) begin
                    push_tag(wavhp_pkg::TAG_DATA);
                    push_le32($urandom_range(0, 4));
                end
            end else begin
                push_random($urandom_range(0, 8));
            end
        end

        if (mode >= 80) begin
            // truncation, mostly around the minimum header length
            if (frame_q.size() > 40 && $urandom_range(0, 3) != 0)
                n = $urandom_range(40, frame_q.size());
            else
                n = $urandom_range(1, frame_q.size());
            while (frame_q.size() > n) frame_q.pop_back();
        end else if (mode >= 70) begin
            // single bit error in one of the tags
            k = $urandom_range(0, 7);
            if (k >= 4) k = k + 4;
            flip = 8'd1 << $urandom_range(0, 7);
            frame_q[k] = frame_q[k] ^ flip;
        end
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_cnt++;
        $display("MISMATCH result %0d: %s got %h want %h", results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Source: drives byte requests, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drv
        int        idle_pct;
        logic      accepted;
        t_byte_req req;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            accepted = s_tvalid && s_tready;
            if (accepted) begin
                parse_byte(s_tdata, s_tlast);
                bytes_sent++;
            end
            phase <= (bytes_sent * 3 < total_items) ? 2'd0 :
                     (bytes_sent * 3 < 2 * total_items) ? 2'd1 : 2'd2;
            if (!s_tvalid || accepted) begin
                idle_pct = (phase == 2'd0) ? 38 : (phase == 2'd1) ? 48 : 0;
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct
                        && !(pending_bytes[0].hold && hdr_results_q.size() != 0)) begin
                    req = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= req.data_byte;
                    s_tlast  <= req.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink: back-pressure and result checks
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        int                 stall_pct;
        wavhp_pkg::t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (hdr_results_q.size() == 0) begin
                    report_mismatch("result with none pending", {30'd0, m_tuser}, 32'd0);
                end else begin
                    want = hdr_results_q.pop_front();
                    if (m_tuser[0] !== want.header_valid)
                        report_mismatch("header_valid", {31'd0, m_tuser[0]},
                                        {31'd0, want.header_valid});
                    if (m_tdata[7:0] !== want.channel_count)
                        report_mismatch("channel_count", {24'd0, m_tdata[7:0]},
                                        {24'd0, want.channel_count});
                    if (m_tdata[39:8] !== want.rate_hz)
                        report_mismatch("rate_hz", m_tdata[39:8], want.rate_hz);
                    if (m_tdata[55:40] !== want.sample_bits)
                        report_mismatch("sample_bits", {16'd0, m_tdata[55:40]},
                                        {16'd0, want.sample_bits});
                    if (m_tdata[87:56] !== want.payload_offset)
                        report_mismatch("payload_offset", m_tdata[87:56], want.payload_offset);
                    if (m_tuser[1] !== want.payload_found)
                        report_mismatch("payload_found", {31'd0, m_tuser[1]},
                                        {31'd0, want.payload_found});
                end
            end
            stall_pct = (phase == 2'd0) ? 48 : (phase == 2'd1) ? 38 : 0;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: too long without any request moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", idle_cycles);
                $display("wav_header_chunk_parser_core test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        clear_parse();

        // directed: extreme single bytes, then good tags in a short buffer
        frame_q.delete();
        frame_q.push_back(8'h00);
        emit_frame(1'b0);
        frame_q.delete();
        frame_q.push_back(8'hFF);
        emit_frame(1'b0);
        frame_q.delete();
        push_tag(wavhp_pkg::TAG_RIFF);
        push_le32(32'hFFFF_FFFF);
        push_tag(wavhp_pkg::TAG_WAVE);
        emit_frame(1'b0);
        n_frames = 3;

        // random buffers; every eighth one waits for the result store to drain
        while (pending_bytes.size() < RANDOM_ITEMS || n_frames < MIN_FRAMES) begin
            build_frame();
            emit_frame(n_frames % 8 == 3);
            n_frames++;
        end
        total_items = pending_bytes.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid) @(posedge i_clk);
        while (hdr_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Parsed %0d bytes in %0d buffers: %0d valid headers, %0d with a data chunk.",
                 bytes_sent, n_frames, valid_cnt, found_cnt);
        $display("Checked %0d results, %0d mismatches.", results_seen, fail_cnt);
        if (fail_cnt == 0 && hdr_results_q.size() == 0) begin
            $display("wav_header_chunk_parser_core test passed");
        end else begin
            $display("wav_header_chunk_parser_core test failed");
        end
        $finish;
    end

endmodule
